### design/swmax_pkg.sv
// Shared types and constants for the sliding window maximum block.
package swmax_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_W  = 7;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;       // latch input transfer, clear sequence on start_req
		logic rd_front;   // read deque front cell
		logic rd_back;    // read deque back cell
		logic retire;     // retire front entry
		logic drop;       // drop back entry
		logic append;     // append sample, advance counters
		logic emit;       // load result register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic cnt_zero;   // deque empty
		logic front_old;  // front entry has left the window
		logic back_less;  // back entry strictly smaller than sample
		logic emit_pend;  // current item produces a result
		logic out_free;   // result register can take a value
	} status_t;

endpackage

### design/swmax_ctrl.sv
// Controller state machine for the sliding window maximum block.
module swmax_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  swmax_pkg::status_t status,
	output swmax_pkg::cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_FRONT_RD  = 7'b0000010,
		S_FRONT_CHK = 7'b0000100,
		S_BACK_RD   = 7'b0001000,
		S_BACK_CHK  = 7'b0010000,
		S_WRITE     = 7'b0100000,
		S_EMIT      = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_FRONT_RD;
				end
			end
			S_FRONT_RD: begin
				if (status.cnt_zero) begin
					state_d = S_BACK_RD;
				end else begin
					cmd.rd_front = 1'b1;
					state_d      = S_FRONT_CHK;
				end
			end
			S_FRONT_CHK: begin
				if (status.front_old) begin
					cmd.retire = 1'b1;
					state_d    = S_FRONT_RD;
				end else begin
					state_d = S_BACK_RD;
				end
			end
			S_BACK_RD: begin
				if (status.cnt_zero) begin
					state_d = S_WRITE;
				end else begin
					cmd.rd_back = 1'b1;
					state_d     = S_BACK_CHK;
				end
			end
			S_BACK_CHK: begin
				if (status.back_less) begin
					cmd.drop = 1'b1;
					state_d  = S_BACK_RD;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				// front read runs alongside the append
				cmd.append   = 1'b1;
				cmd.rd_front = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (!status.emit_pend) begin
					state_d = S_IDLE;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### design/swmax_datapath.sv
// Datapath: deque memory, pointers, counters and result register.
module swmax_datapath #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swmax_pkg::CFG_W-1:0]         window_size,
	input  logic signed [swmax_pkg::DATA_W-1:0] sample,
	input  logic                                start_req,
	input  swmax_pkg::cmd_t                     cmd,
	output swmax_pkg::status_t                  status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [swmax_pkg::DATA_W-1:0] window_max
);

	localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW      = $clog2(MAX_WINDOW + 1);
	localparam int POS_MOD = 2 * MAX_WINDOW;
	localparam int PW      = $clog2(POS_MOD);

	logic signed [swmax_pkg::DATA_W-1:0] mem_val [MAX_WINDOW];
	logic [PW-1:0]                       mem_pos [MAX_WINDOW];

	logic [AW-1:0]                       head_q;
	logic [CW-1:0]                       count_q;
	logic [PW-1:0]                       pos_q;
	logic [CW-1:0]                       seen_q;
	logic [swmax_pkg::CFG_W-1:0]         wsize_q;
	logic                                emit_pend_q;
	logic                                out_valid_q;
	logic signed [swmax_pkg::DATA_W-1:0] sample_q;
	logic signed [swmax_pkg::DATA_W-1:0] rd_val_q;
	logic [PW-1:0]                       rd_pos_q;
	logic                                front_new_q;
	logic signed [swmax_pkg::DATA_W-1:0] out_data_q;

	logic [31:0]   w_full;
	logic [CW-1:0] w_eff;
	logic [CW:0]   tail_sum, last_sum;
	logic [AW-1:0] tail_idx, last_idx, rd_addr, head_next;
	logic [PW:0]   age;
	logic [PW-1:0] pos_next;
	logic [CW-1:0] seen_clamp, seen_next;
	logic          cnt_full;

	// Effective window: zero reads as one, clamp at the deque depth
	always_comb begin
		if (wsize_q == '0) begin
			w_full = 32'd1;
		end else if (32'(wsize_q) > 32'(MAX_WINDOW)) begin
			w_full = 32'(MAX_WINDOW);
		end else begin
			w_full = 32'(wsize_q);
		end
		w_eff = w_full[CW-1:0];
	end

	// Circular cell indexes
	always_comb begin
		tail_sum = (CW+1)'(head_q) + (CW+1)'(count_q);
		last_sum = tail_sum - (CW+1)'(1);
		tail_idx = (tail_sum >= (CW+1)'(MAX_WINDOW)) ?
			AW'(tail_sum - (CW+1)'(MAX_WINDOW)) : AW'(tail_sum);
		last_idx = (last_sum >= (CW+1)'(MAX_WINDOW)) ?
			AW'(last_sum - (CW+1)'(MAX_WINDOW)) : AW'(last_sum);
		head_next = (head_q == AW'(MAX_WINDOW - 1)) ? '0 : head_q + AW'(1);
		rd_addr   = cmd.rd_back ? last_idx : head_q;
		cnt_full  = (count_q == CW'(MAX_WINDOW));
	end

	// Age of the front entry, positions kept modulo 2*MAX_WINDOW
	always_comb begin
		if (pos_q >= rd_pos_q) begin
			age = (PW+1)'(pos_q) - (PW+1)'(rd_pos_q);
		end else begin
			age = (PW+1)'(pos_q) + (PW+1)'(POS_MOD) - (PW+1)'(rd_pos_q);
		end
		pos_next = (pos_q == PW'(POS_MOD - 1)) ? '0 : pos_q + PW'(1);
	end

	always_comb begin
		seen_clamp = (seen_q > w_eff) ? w_eff : seen_q;
		seen_next  = (seen_clamp < w_eff) ? seen_clamp + CW'(1) : seen_clamp;
	end

	assign status.cnt_zero  = (count_q == '0);
	assign status.front_old = (age >= (PW+1)'(w_eff));
	assign status.back_less = (rd_val_q < sample_q);
	assign status.emit_pend = emit_pend_q;
	assign status.out_free  = !out_valid_q || out_ready;

	// Deque memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.append && !cnt_full) begin
			mem_val[tail_idx] <= sample_q;
			mem_pos[tail_idx] <= pos_q;
		end
		if (cmd.rd_front || cmd.rd_back) begin
			rd_val_q <= mem_val[rd_addr];
			rd_pos_q <= mem_pos[rd_addr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			seen_q      <= '0;
			wsize_q     <= swmax_pkg::CFG_W'(1);
			emit_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				wsize_q <= window_size;
			end
			if (cmd.load && start_req) begin
				head_q  <= '0;
				count_q <= '0;
				pos_q   <= '0;
				seen_q  <= '0;
			end
			if (cmd.retire) begin
				head_q  <= head_next;
				count_q <= count_q - CW'(1);
			end
			if (cmd.drop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.append) begin
				if (!cnt_full) begin
					count_q <= count_q + CW'(1);
				end
				pos_q       <= pos_next;
				seen_q      <= seen_next;
				emit_pend_q <= (seen_next >= w_eff);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
		end
		if (cmd.append) begin
			front_new_q <= (count_q == '0);
		end
		if (cmd.emit) begin
			out_data_q <= front_new_q ? sample_q : rd_val_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = out_data_q;

endmodule

### design/sliding_window_maximum_top.sv
// Top level of the sliding window maximum block.
//
// Channel   Direction  Handshake             Payload
// config    in         cfg_we                window_size[6:0]
// input     in         in_valid / in_ready   sample[31:0] signed, start_req
// result    out        out_valid / out_ready window_max[31:0] signed
//
// One input transfer at a time: each item reads and retires expired entries at the front,
// then reads and drops smaller entries at the back, appends the sample and hands off the
// result; the deque memory has a single read port, so entries are checked one by one.
// A waiting result sits in its own register, so the next transfer is taken meanwhile;
// only a second result finding it still full stalls the item.
// Async reset clears pointers, counters and the window register (to 1).
module sliding_window_maximum_top #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swmax_pkg::CFG_W-1:0]         window_size,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [swmax_pkg::DATA_W-1:0] sample,
	input  logic                                start_req,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [swmax_pkg::DATA_W-1:0] window_max
);

	swmax_pkg::cmd_t    cmd;
	swmax_pkg::status_t status;

	// Sequencer: retire loop, pop loop, append, result hand-off
	swmax_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Deque memory, counters, compares and result register
	swmax_datapath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.window_size (window_size),
		.sample      (sample),
		.start_req   (start_req),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.window_max  (window_max)
	);

	// An input transfer starts a multi-cycle item; no transfer right after
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in progress");

	// A result never overwrites one that has not been transferred
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result register overwritten");

	// Entries are removed only from a non-empty deque
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.retire || cmd.drop) |-> !status.cnt_zero)
		else $error("pop from empty deque");

endmodule
